>>> design/tgc_pkg.sv
`default_nettype none
package tgc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int THR_BITS = 12;
  localparam int THR_SQ_BITS = 2 * THR_BITS;
  localparam int TIMEOUT_BITS = 16;
  localparam int PAGE_BITS = 8;
  localparam int TIME_BITS = 32;
  localparam int BUTTON_BITS = 9;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_PAGE = 2'd2;

  localparam logic [THR_BITS-1:0] THR_RESET = 12'd10;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd300;
  localparam logic [PAGE_BITS-1:0] PAGE_RESET = 8'd0;
  localparam logic signed [BUTTON_BITS-1:0] NO_BUTTON = -9'sd1;

  typedef enum logic [1:0] {
    ACT_DOWN = 2'd0,
    ACT_MOTION = 2'd1,
    ACT_UP = 2'd2,
    ACT_CANCEL = 2'd3
  } action_t;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_CLICK = 3'd1;
  localparam logic [2:0] KIND_SCROLL = 3'd2;
  localparam logic [2:0] KIND_DRAG = 3'd3;
  localparam logic [2:0] KIND_SWIPE = 3'd4;

  localparam logic [1:0] GEST_NONE = 2'd0;
  localparam logic [1:0] GEST_POTENTIAL = 2'd1;
  localparam logic [1:0] GEST_HORZ = 2'd2;
  localparam logic [1:0] GEST_VERT = 2'd3;

  typedef enum logic [3:0] {
    MODE_NONE = 4'b0001,
    MODE_POTENTIAL = 4'b0010,
    MODE_HORZ = 4'b0100,
    MODE_VERT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [THR_SQ_BITS-1:0] thr_sq;
    logic [TIMEOUT_BITS-1:0] click_timeout;
    logic [PAGE_BITS-1:0] active_page;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/tgc_cfg.sv
`default_nettype none
module tgc_cfg
  import tgc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  logic [THR_BITS-1:0] thr;

  assign thr = cfg_data[THR_BITS-1:0];

  // The threshold is kept squared so the distance test needs no extra multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_sq <= THR_SQ_BITS'(THR_RESET) * THR_SQ_BITS'(THR_RESET);
      cfg.click_timeout <= TIMEOUT_RESET;
      cfg.active_page <= PAGE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DRAG_THRESHOLD: cfg.thr_sq <= THR_SQ_BITS'(thr) * THR_SQ_BITS'(thr);
        CFG_CLICK_TIMEOUT:  cfg.click_timeout <= cfg_data[TIMEOUT_BITS-1:0];
        CFG_ACTIVE_PAGE:    cfg.active_page <= cfg_data[PAGE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/tgc_core.sv
`default_nettype none
module tgc_core
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [1:0]                    action,
  input  wire logic [COORD_BITS-1:0]         pos_x,
  input  wire logic [COORD_BITS-1:0]         pos_y,
  input  wire logic [TIME_BITS-1:0]          time_ms,
  input  wire logic signed [BUTTON_BITS-1:0] hit_button,
  input  wire cfg_t                          cfg,
  output logic [2:0]                         event_kind,
  output logic [7:0]                         click_button,
  output logic signed [COORD_BITS:0]         scroll_delta,
  output logic signed [COORD_BITS:0]         swipe_dx,
  output logic [1:0]                         gesture_now,
  output logic                               dragging_page
);

  localparam int SQ_BITS = 2 * COORD_BITS + 1;
  localparam int CMP_BITS = (SQ_BITS > THR_SQ_BITS) ? SQ_BITS : THR_SQ_BITS;

  mode_t mode, mode_next;
  logic signed [BUTTON_BITS-1:0] held_button, held_button_next;
  logic signed [BUTTON_BITS-1:0] down_page;
  logic [TIME_BITS-1:0] start_time;
  logic [COORD_BITS-1:0] start_x, start_y, prev_y;

  logic signed [COORD_BITS:0] dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay;
  logic [CMP_BITS-1:0] dist_sq, thr_sq;
  logic [TIME_BITS-1:0] elapsed;
  logic is_click;

  assign dx = $signed({1'b0, pos_x}) - $signed({1'b0, start_x});
  assign dy = $signed({1'b0, pos_y}) - $signed({1'b0, start_y});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign dist_sq = CMP_BITS'(ax) * CMP_BITS'(ax) + CMP_BITS'(ay) * CMP_BITS'(ay);
  assign thr_sq = CMP_BITS'(cfg.thr_sq);
  assign elapsed = time_ms - start_time;

  assign is_click = (elapsed < TIME_BITS'(cfg.click_timeout)) && (dist_sq < thr_sq)
      && !held_button[BUTTON_BITS-1]
      && (down_page == $signed({1'b0, cfg.active_page}));

  always_comb begin
    mode_next = mode;
    held_button_next = held_button;
    event_kind = KIND_NONE;
    click_button = '0;
    scroll_delta = '0;
    swipe_dx = '0;
    case (action)
      ACT_DOWN: begin
        mode_next = MODE_POTENTIAL;
        held_button_next = hit_button;
      end
      ACT_MOTION: begin
        if (mode != MODE_NONE) begin
          if (mode == MODE_POTENTIAL && dist_sq > thr_sq) begin
            mode_next = (ax > ay) ? MODE_HORZ : MODE_VERT;
          end
          if (mode_next == MODE_VERT) begin
            event_kind = KIND_SCROLL;
            scroll_delta = $signed({1'b0, prev_y}) - $signed({1'b0, pos_y});
          end else if (mode_next == MODE_HORZ) begin
            event_kind = KIND_DRAG;
            swipe_dx = dx;
          end
        end
      end
      ACT_UP: begin
        if (mode != MODE_NONE) begin
          if (mode == MODE_POTENTIAL && is_click) begin
            event_kind = KIND_CLICK;
            click_button = held_button[7:0];
          end else if (mode == MODE_HORZ) begin
            event_kind = KIND_SWIPE;
            swipe_dx = dx;
          end
          mode_next = MODE_NONE;
          held_button_next = NO_BUTTON;
        end
      end
      default: begin
        mode_next = MODE_NONE;
        held_button_next = NO_BUTTON;
      end
    endcase
  end

  always_comb begin
    case (mode_next)
      MODE_POTENTIAL: gesture_now = GEST_POTENTIAL;
      MODE_HORZ:      gesture_now = GEST_HORZ;
      MODE_VERT:      gesture_now = GEST_VERT;
      default:        gesture_now = GEST_NONE;
    endcase
  end

  assign dragging_page = (mode_next == MODE_HORZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
      held_button <= NO_BUTTON;
      down_page <= NO_BUTTON;
      start_time <= '0;
      start_x <= '0;
      start_y <= '0;
      prev_y <= '0;
    end else if (go) begin
      mode <= mode_next;
      held_button <= held_button_next;
      if (action == ACT_DOWN) begin
        down_page <= $signed({1'b0, cfg.active_page});
        start_time <= time_ms;
        start_x <= pos_x;
        start_y <= pos_y;
        prev_y <= pos_y;
      end else if (action == ACT_MOTION && mode != MODE_NONE) begin
        prev_y <= pos_y;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/touch_gesture_classifier_unit.sv
`default_nettype none
// An accepted event word is registered in the s1 stage, and its result word in the output register.
// Throughput: one event word per cycle while event_stall is low; the gesture state is updated in the
// single classification stage, so each event sees the state left by the last.
// Reset (rst, synchronous, active high) clears the gesture state, restores the
// register defaults and empties both pipeline registers.
module touch_gesture_classifier_unit
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          event_valid,
  output logic                               event_stall,
  input  wire logic [1:0]                    action,
  input  wire logic [COORD_BITS-1:0]         pos_x,
  input  wire logic [COORD_BITS-1:0]         pos_y,
  input  wire logic [TIME_BITS-1:0]          time_ms,
  input  wire logic signed [BUTTON_BITS-1:0] hit_button,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [2:0]                         event_kind,
  output logic [7:0]                         click_button,
  output logic signed [COORD_BITS:0]         scroll_delta,
  output logic signed [COORD_BITS:0]         swipe_dx,
  output logic [1:0]                         gesture_now,
  output logic                               dragging_page,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  cfg_t cfg;

  logic s1_valid;
  logic [1:0] s1_action;
  logic [COORD_BITS-1:0] s1_x, s1_y;
  logic [TIME_BITS-1:0] s1_time;
  logic signed [BUTTON_BITS-1:0] s1_hit;
  logic advance;
  logic event_take;

  logic [2:0] kind_c;
  logic [7:0] button_c;
  logic signed [COORD_BITS:0] scroll_c, swipe_c;
  logic [1:0] gesture_c;
  logic dragging_c;

  assign cfg_ready = 1'b1;
  assign advance = !result_valid || !result_stall;
  assign event_stall = s1_valid && !advance;
  assign event_take = event_valid && !event_stall;

  tgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgc_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (s1_valid && advance),
    .action        (s1_action),
    .pos_x         (s1_x),
    .pos_y         (s1_y),
    .time_ms       (s1_time),
    .hit_button    (s1_hit),
    .cfg           (cfg),
    .event_kind    (kind_c),
    .click_button  (button_c),
    .scroll_delta  (scroll_c),
    .swipe_dx      (swipe_c),
    .gesture_now   (gesture_c),
    .dragging_page (dragging_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!event_stall) begin
      s1_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_take) begin
      s1_action <= action;
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_time <= time_ms;
      s1_hit <= hit_button;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      event_kind <= kind_c;
      click_button <= button_c;
      scroll_delta <= scroll_c;
      swipe_dx <= swipe_c;
      gesture_now <= gesture_c;
      dragging_page <= dragging_c;
    end
  end

endmodule
`default_nettype wire
